// ===== design/fcl_pkg.sv =====
package fcl_pkg;

  // Field widths fixed by the interface
  localparam int OP_W       = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 9;
  localparam int VALUE_W    = 16;
  localparam int NEURON_W   = 6;
  localparam int SUM_W      = 32;
  localparam int IN_CNT_W   = 10;
  localparam int OUT_CNT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Default sizes of the stores
  localparam int DEF_MAX_INPUTS  = 512;
  localparam int DEF_MAX_OUTPUTS = 64;

  // Register reset values
  localparam logic [IN_CNT_W-1:0]  INPUT_COUNT_RST  = IN_CNT_W'(400);
  localparam logic [OUT_CNT_W-1:0] OUTPUT_COUNT_RST = OUT_CNT_W'(64);

  // Saturation limits of the result
  localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_WEIGHT = 2'd0,
    OP_WRITE_ACT    = 2'd1,
    OP_RUN          = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_COUNT  = 2'd0,
    REG_OUTPUT_COUNT = 2'd1
  } reg_idx_t;

  // Controller -> datapath
  typedef struct packed {
    logic wr_weight;
    logic wr_act;
    logic issue;
    logic load_out;
    logic last;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic busy;
    logic out_free;
  } dp_stat_t;

  // Index width for a store of n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== design/fcl_ctrl.sv =====
module fcl_ctrl
  import fcl_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [OP_W-1:0]                             op,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]                        cfg_index,
  input  logic [CFG_DATA_W-1:0]                       cfg_data,
  output dp_cmd_t                                     cmd,
  input  dp_stat_t                                    stat,
  output logic [idx_w(MAX_INPUTS*MAX_OUTPUTS)-1:0]    rd_waddr,
  output logic [idx_w(MAX_INPUTS)-1:0]                rd_aaddr,
  output logic [idx_w(MAX_OUTPUTS)-1:0]               neuron_idx
);

  localparam int NIN_W   = $clog2(MAX_INPUTS + 1);
  localparam int NOUT_W  = $clog2(MAX_OUTPUTS + 1);
  localparam int N_W     = idx_w(MAX_OUTPUTS);
  localparam int AADDR_W = idx_w(MAX_INPUTS);
  localparam int WADDR_W = idx_w(MAX_INPUTS * MAX_OUTPUTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_EMIT
  } state_t;

  state_t               state;
  logic [IN_CNT_W-1:0]  input_count;
  logic [OUT_CNT_W-1:0] output_count;
  logic [NIN_W-1:0]     i_cnt;
  logic [N_W-1:0]       n_cnt;
  logic [WADDR_W-1:0]   row_base;
  logic [NIN_W-1:0]     nin;
  logic [NOUT_W-1:0]    nout;

  // Clamp counts to the store size
  always_comb begin
    nin  = (32'(input_count) > 32'(MAX_INPUTS)) ? NIN_W'(MAX_INPUTS) : NIN_W'(input_count);
    nout = (32'(output_count) > 32'(MAX_OUTPUTS)) ?
           NOUT_W'(MAX_OUTPUTS) : NOUT_W'(output_count);
  end

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign rd_aaddr   = AADDR_W'(i_cnt);
  assign rd_waddr   = row_base + WADDR_W'(i_cnt);
  assign neuron_idx = n_cnt;

  always_comb begin
    cmd.wr_weight = (state == S_IDLE) && in_valid && (op == OP_WRITE_WEIGHT);
    cmd.wr_act    = (state == S_IDLE) && in_valid && (op == OP_WRITE_ACT);
    cmd.issue     = (state == S_MAC) && (i_cnt != nin);
    cmd.load_out  = (state == S_EMIT) && !stat.busy && stat.out_free;
    cmd.last      = (NOUT_W'(n_cnt) == (nout - NOUT_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      input_count  <= INPUT_COUNT_RST;
      output_count <= OUTPUT_COUNT_RST;
      i_cnt        <= '0;
      n_cnt        <= '0;
      row_base     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_INPUT_COUNT:  input_count  <= cfg_data[IN_CNT_W-1:0];
          REG_OUTPUT_COUNT: output_count <= cfg_data[OUT_CNT_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid && (op == OP_RUN) && (nout != '0)) begin
            state    <= S_MAC;
            i_cnt    <= '0;
            n_cnt    <= '0;
            row_base <= '0;
          end
        end
        S_MAC: begin
          if (i_cnt == nin) begin
            state <= S_EMIT;
          end else begin
            i_cnt <= i_cnt + NIN_W'(1);
          end
        end
        S_EMIT: begin
          if (cmd.load_out) begin
            if (cmd.last) begin
              state <= S_IDLE;
            end else begin
              state    <= S_MAC;
              i_cnt    <= '0;
              n_cnt    <= n_cnt + N_W'(1);
              row_base <= row_base + WADDR_W'(MAX_INPUTS);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (i_cnt < nin))
    else $error("read issued past the end of the row");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && cmd.last) |=> (state == S_IDLE))
    else $error("run did not end after the final neuron");

  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !(cmd.wr_weight || cmd.wr_act))
    else $error("store write during a run");

endmodule

// ===== design/fcl_datapath.sv =====
module fcl_datapath
  import fcl_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  dp_cmd_t                                     cmd,
  output dp_stat_t                                    stat,
  input  logic [ROW_W-1:0]                            row,
  input  logic [COL_W-1:0]                            col,
  input  logic [VALUE_W-1:0]                          value,
  input  logic [idx_w(MAX_INPUTS*MAX_OUTPUTS)-1:0]    rd_waddr,
  input  logic [idx_w(MAX_INPUTS)-1:0]                rd_aaddr,
  input  logic [idx_w(MAX_OUTPUTS)-1:0]               neuron_idx,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [NEURON_W-1:0]                         neuron,
  output logic [SUM_W-1:0]                            sum,
  output logic                                        last
);

  localparam int AADDR_W = idx_w(MAX_INPUTS);
  localparam int WADDR_W = idx_w(MAX_INPUTS * MAX_OUTPUTS);
  localparam int WDEPTH  = MAX_INPUTS * MAX_OUTPUTS;
  // 16x16 products, up to MAX_INPUTS of them, never wrap
  localparam int ACC_W   = 2 * VALUE_W + 1 + idx_w(MAX_INPUTS);

  logic [VALUE_W-1:0] wmem [WDEPTH];
  logic [VALUE_W-1:0] amem [MAX_INPUTS];

  logic                      row_ok;
  logic                      col_ok;
  logic [WADDR_W-1:0]        wr_waddr;
  logic signed [VALUE_W-1:0] w_rd;
  logic signed [VALUE_W-1:0] a_rd;
  logic                      rd_valid;
  logic signed [SUM_W-1:0]   prod;
  logic                      prod_valid;
  logic signed [ACC_W-1:0]   acc;
  logic                      ovf;
  logic [SUM_W-1:0]          sum_sat;

  assign row_ok   = (32'(row) < 32'(MAX_OUTPUTS));
  assign col_ok   = (32'(col) < 32'(MAX_INPUTS));
  assign wr_waddr = WADDR_W'(32'(row) * 32'(MAX_INPUTS) + 32'(col));

  always_ff @(posedge clk) begin
    if (cmd.wr_weight && row_ok && col_ok) begin
      wmem[wr_waddr] <= value;
    end
    if (cmd.issue) begin
      w_rd <= wmem[rd_waddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_act && col_ok) begin
      amem[AADDR_W'(col)] <= value;
    end
    if (cmd.issue) begin
      a_rd <= amem[rd_aaddr];
    end
  end

  // Multiply stage, then accumulate
  always_ff @(posedge clk) begin
    prod <= w_rd * a_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      rd_valid   <= cmd.issue;
      prod_valid <= rd_valid;
      if (cmd.load_out) begin
        acc <= '0;
      end else if (prod_valid) begin
        acc <= acc + {{(ACC_W-SUM_W){prod[SUM_W-1]}}, prod};
      end
    end
  end

  // Upper bits not all equal to the sign means the sum left the 32-bit range
  assign ovf     = (acc[ACC_W-1:SUM_W-1] != {(ACC_W-SUM_W+1){acc[ACC_W-1]}});
  assign sum_sat = ovf ? (acc[ACC_W-1] ? SUM_MIN : SUM_MAX) : acc[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      neuron <= NEURON_W'(neuron_idx);
      sum    <= sum_sat;
      last   <= cmd.last;
    end
  end

  assign stat.busy     = rd_valid || prod_valid;
  assign stat.out_free = !out_valid || out_ready;

  a_load_when_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(rd_valid || prod_valid))
    else $error("result loaded while products still in flight");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_acc_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (acc == '0))
    else $error("accumulator not cleared after result load");

endmodule

// ===== design/int16_fc_layer_saturating_unit.sv =====
// Throughput: one write transaction per cycle while no run is in progress; a run
// with a nonzero output count holds off input until the result of its last neuron
// has been loaded into the output register, so output stalls lengthen it.
// Reset: synchronous, clears control state and loads input_count = 400 and
// output_count = 64; weight and activation stores are not cleared.
module int16_fc_layer_saturating_unit
  import fcl_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input item channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       op,
  input  logic [ROW_W-1:0]      row,
  input  logic [COL_W-1:0]      col,
  input  logic [VALUE_W-1:0]    value,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NEURON_W-1:0]   neuron,
  output logic [SUM_W-1:0]      sum,
  output logic                  last,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Store address widths follow the parameters
  localparam int AADDR_W = idx_w(MAX_INPUTS);
  localparam int WADDR_W = idx_w(MAX_INPUTS * MAX_OUTPUTS);
  localparam int N_W     = idx_w(MAX_OUTPUTS);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [WADDR_W-1:0] rd_waddr;
  logic [AADDR_W-1:0] rd_aaddr;
  logic [N_W-1:0]     neuron_idx;

  // Controller: decodes input transactions, walks neurons and inputs of a
  // run, issues one weight/activation read per cycle, then waits for the
  // MAC pipe to drain and for the output register to free up.
  fcl_ctrl #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .rd_waddr   (rd_waddr),
    .rd_aaddr   (rd_aaddr),
    .neuron_idx (neuron_idx)
  );

  // Datapath: weight and activation stores (registered read), a multiply
  // stage, a wide accumulator, saturation and the output register, which
  // holds a finished result while the controller may go on.
  fcl_datapath #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .row        (row),
    .col        (col),
    .value      (value),
    .rd_waddr   (rd_waddr),
    .rd_aaddr   (rd_aaddr),
    .neuron_idx (neuron_idx),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .neuron     (neuron),
    .sum        (sum),
    .last       (last)
  );

endmodule

// ===== verif/tb_int16_fc_layer_saturating_unit.sv =====
`timescale 1ns / 1ps

module tb_int16_fc_layer_saturating_unit;
  import fcl_pkg::*;

  localparam int MAX_IN  = DEF_MAX_INPUTS;
  localparam int MAX_OUT = DEF_MAX_OUTPUTS;

  // Op code that the package leaves unnamed; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Quiet time before a config write, well past the drain of the last neuron.
  localparam int SETTLE_CYCLES  = 2 * (MAX_IN + 8);
  // Longest stretch without any transaction, well above the time a full-width
  // neuron takes and above the config settle.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RAND_PER_PHASE = 20;
  localparam int MAX_REPORTS    = 40;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct {
    logic [NEURON_W-1:0] neuron;
    logic [SUM_W-1:0]    sum;
    logic                last;
  } neuron_sum_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       op = '0;
  logic [ROW_W-1:0]      row = '0;
  logic [COL_W-1:0]      col = '0;
  logic [VALUE_W-1:0]    value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [NEURON_W-1:0]   neuron;
  logic [SUM_W-1:0]      sum;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int16_fc_layer_saturating_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .row(row), .col(col), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .neuron(neuron), .sum(sum), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the layer: stores, config and the sums still owed by the block
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] weight_mem [MAX_OUT][MAX_IN];
  logic signed [VALUE_W-1:0] act_mem [MAX_IN];
  int in_count_reg  = INPUT_COUNT_RST;
  int out_count_reg = OUTPUT_COUNT_RST;
  neuron_sum_t pending_sums [$];

  // Stimulus side: queued commands and which store entries hold real data,
  // so that no run ever reads an entry that was never written.
  cmd_t cmd_q [$];
  cmd_t cur_cmd;
  bit   w_loaded [MAX_OUT][MAX_IN];
  bit   a_loaded [MAX_IN];
  int   lay_nin  = INPUT_COUNT_RST;
  int   lay_nout = OUTPUT_COUNT_RST;

  int n_err = 0;
  int n_writes = 0;
  int n_runs = 0;
  int n_checked = 0;
  int n_sat = 0;
  int n_cfg = 0;
  int cycle_cnt = 0;
  int quiet_cnt = 0;

  function automatic int clamp_count(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  // ~14% idle, except in a recurring calm window with no breaks
  function automatic bit take_break();
    return ((cycle_cnt % 8192) < 6144) && ($urandom_range(99) < 14);
  endfunction

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                 input logic [SUM_W-1:0] want);
    if (n_err < MAX_REPORTS)
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    n_err++;
  endtask

  // Update the shadow for one accepted transaction; a run queues its sums.
  task automatic apply_cmd(input cmd_t c);
    int nin;
    int nout;
    longint acc;
    neuron_sum_t r;
    case (c.op)
      OP_WRITE_WEIGHT: begin
        weight_mem[c.row][c.col] = c.value;
        n_writes++;
      end
      OP_WRITE_ACT: begin
        act_mem[c.col] = c.value;
        n_writes++;
      end
      OP_RUN: begin
        n_runs++;
        nin  = clamp_count(in_count_reg, MAX_IN);
        nout = clamp_count(out_count_reg, MAX_OUT);
        for (int n = 0; n < nout; n++) begin
          acc = 0;
          for (int i = 0; i < nin; i++)
            acc += longint'(weight_mem[n][i]) * longint'(act_mem[i]);
          r.neuron = NEURON_W'(n);
          r.last   = (n == nout - 1);
          if (acc > longint'($signed(SUM_MAX))) begin
            r.sum = SUM_MAX;
            n_sat++;
          end else if (acc < longint'($signed(SUM_MIN))) begin
            r.sum = SUM_MIN;
            n_sat++;
          end else begin
            r.sum = acc[SUM_W-1:0];
          end
          pending_sums.push_back(r);
        end
      end
      default: ;  // unused code, no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued commands, holds payload until the transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        apply_cmd(cur_cmd);
      if (in_valid && !in_ready) begin
        // stalled: keep valid and payload as they are
      end else if (cmd_q.size() != 0 && !take_break()) begin
        cur_cmd  = cmd_q.pop_front();
        op       <= cur_cmd.op;
        row      <= cur_cmd.row;
        col      <= cur_cmd.col;
        value    <= cur_cmd.value;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, each result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    neuron_sum_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_sums.size() == 0) begin
          report_mismatch("unexpected result, sum", sum, '0);
        end else begin
          w = pending_sums.pop_front();
          n_checked++;
          if (neuron !== w.neuron)
            report_mismatch("neuron", SUM_W'(neuron), SUM_W'(w.neuron));
          if (sum !== w.sum)
            report_mismatch($sformatf("sum of neuron %0d", w.neuron), sum, w.sum);
          if (last !== w.last)
            report_mismatch($sformatf("last of neuron %0d", w.neuron),
                            SUM_W'(last), SUM_W'(w.last));
        end
      end
      out_ready <= !take_break();
    end
  end

  // Watchdog: ends the run when no transaction of any kind happens for long
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
      if (quiet_cnt >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d sums outstanding",
                 quiet_cnt, pending_sums.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input logic [OP_W-1:0] o, input int r, input int c,
                          input logic [VALUE_W-1:0] v);
    cmd_t x;
    x.op    = o;
    x.row   = ROW_W'(r);
    x.col   = COL_W'(c);
    x.value = v;
    if (o == OP_WRITE_WEIGHT) w_loaded[x.row][x.col] = 1'b1;
    if (o == OP_WRITE_ACT) a_loaded[x.col] = 1'b1;
    cmd_q.push_back(x);
  endtask

  // Row, col and value of a run are don't-care: fill them with noise.
  task automatic push_run();
    push_cmd(OP_RUN, $urandom_range(MAX_OUT - 1), $urandom_range(MAX_IN - 1),
             VALUE_W'($urandom));
  endtask

  // Corner values often; "loud" phases use only full-scale magnitudes so
  // that sums saturate regularly.
  function automatic logic [VALUE_W-1:0] pick_value(input bit loud);
    if (loud) return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    if ($urandom_range(3) != 0) return VALUE_W'($urandom);
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'h0001;
    endcase
  endfunction

  // Load every entry a run of this size reads that still holds no data.
  task automatic fill_region(input int nin, input int nout, input bit loud);
    for (int r = 0; r < nout; r++)
      for (int c = 0; c < nin; c++)
        if (!w_loaded[r][c]) push_cmd(OP_WRITE_WEIGHT, r, c, pick_value(loud));
    for (int c = 0; c < nin; c++)
      if (!a_loaded[c]) push_cmd(OP_WRITE_ACT, 0, c, pick_value(loud));
  endtask

  // Sampled at the falling edge so the driver's updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || pending_sums.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_INPUT_COUNT:  in_count_reg  = data;
      REG_OUTPUT_COUNT: out_count_reg = data;
      default: ;
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  // New layer shape: only once the block is idle
  task automatic set_layer(input int ic, input int oc);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_INPUT_COUNT, ic);
    write_reg(REG_OUTPUT_COUNT, oc);
    lay_nin  = clamp_count(ic, MAX_IN);
    lay_nout = clamp_count(oc, MAX_OUT);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  ic;
    int  oc;
    int  k;
    int  roll;
    bit  loud;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // One input per neuron, output count left at its reset value: one run
    // checks the output count reset and the widest neuron count.
    write_reg(REG_INPUT_COUNT, 1);
    lay_nin = 1;
    fill_region(lay_nin, lay_nout, 1'b0);
    push_run();

    // Directed: saturation both ways, exact cancellation, field extremes,
    // unused op code.
    set_layer(3, 2);
    for (int i = 0; i < 3; i++) begin
      push_cmd(OP_WRITE_WEIGHT, 0, i, 16'h8000);
      push_cmd(OP_WRITE_WEIGHT, 1, i, 16'h7FFF);
      push_cmd(OP_WRITE_ACT, 0, i, 16'h8000);
    end
    push_run();  // neuron 0 clips high, neuron 1 clips low
    for (int i = 0; i < 3; i++) push_cmd(OP_WRITE_ACT, 0, i, 16'h7FFF);
    push_run();  // the other way round
    push_cmd(OP_WRITE_ACT, 0, 0, 16'h0001);
    push_cmd(OP_WRITE_ACT, 0, 1, 16'hFFFF);
    push_cmd(OP_WRITE_ACT, 0, 2, 16'h0000);
    push_run();  // terms cancel to zero
    push_cmd(OP_WRITE_WEIGHT, MAX_OUT - 1, MAX_IN - 1, 16'h8000);
    push_cmd(OP_WRITE_ACT, MAX_OUT - 1, MAX_IN - 1, 16'h7FFF);
    push_cmd(OP_UNUSED, MAX_OUT - 1, MAX_IN - 1, 16'hFFFF);
    push_cmd(OP_UNUSED, 0, 0, 16'h0000);
    push_run();

    // Smallest shape
    set_layer(1, 1);
    fill_region(lay_nin, lay_nout, 1'b0);
    push_run();
    push_cmd(OP_WRITE_ACT, 0, 0, pick_value(1'b0));
    push_run();

    // Zero inputs: every neuron sums to zero
    set_layer(0, 5);
    push_run();

    // Zero outputs: a run gives nothing back
    set_layer(8, 0);
    push_cmd(OP_WRITE_WEIGHT, 2, 3, pick_value(1'b0));
    push_run();
    push_cmd(OP_WRITE_ACT, 0, 4, pick_value(1'b0));
    push_run();

    // Oversized output count clips to the store size
    set_layer(1, 127);
    fill_region(lay_nin, lay_nout, 1'b0);
    push_run();

    // Random phases: shape loaded first, then writes mixed with runs
    for (int p = 0; p < 4; p++) begin
      case (p)
        2: begin
          ic = 1;
          oc = MAX_OUT;
        end
        3: begin
          ic = $urandom_range(1, 8);
          oc = $urandom_range(1, 3);
        end
        default: begin
          ic = $urandom_range(1, 8);
          oc = $urandom_range(1, 4);
        end
      endcase
      loud = (p == 1);
      set_layer(ic, oc);
      fill_region(lay_nin, lay_nout, loud);
      k = 0;
      while (k < RAND_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 44) begin
          if ($urandom_range(9) < 7)
            push_cmd(OP_WRITE_WEIGHT, $urandom_range(lay_nout - 1),
                     $urandom_range(lay_nin - 1), pick_value(loud));
          else
            push_cmd(OP_WRITE_WEIGHT, $urandom_range(MAX_OUT - 1),
                     $urandom_range(MAX_IN - 1), pick_value(loud));
          k++;
        end else if (roll < 78) begin
          if ($urandom_range(9) < 7)
            push_cmd(OP_WRITE_ACT, $urandom_range(MAX_OUT - 1),
                     $urandom_range(lay_nin - 1), pick_value(loud));
          else
            push_cmd(OP_WRITE_ACT, $urandom_range(MAX_OUT - 1),
                     $urandom_range(MAX_IN - 1), pick_value(loud));
          k++;
        end else if (roll < 93) begin
          push_run();
          k++;
        end else begin
          // ignored code: noise only, not counted
          push_cmd(OP_UNUSED, $urandom_range(MAX_OUT - 1), $urandom_range(MAX_IN - 1),
                   VALUE_W'($urandom));
        end
        // In the first phase the sender holds off mid-phase until every owed sum has come back
        if (p == 0 && k == RAND_PER_PHASE / 2) wait_drained();
      end
      push_run();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d store writes and %0d layer runs over %0d register writes",
             n_writes, n_runs, n_cfg);
    $display("compared %0d neuron sums, %0d expected at a clip limit", n_checked, n_sat);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fcl_pkg.sv
design/fcl_ctrl.sv
design/fcl_datapath.sv
design/int16_fc_layer_saturating_unit.sv
verif/tb_int16_fc_layer_saturating_unit.sv
